>>> rtl/ssmp_pkg.sv
package ssmp_pkg;

  localparam int N_STATE    = 4;
  localparam int N_CTRL     = 2;
  localparam int N_OUT      = 2;
  localparam int DATA_WIDTH = 16;
  localparam int COEF_WIDTH = 16;

  localparam int B_BASE      = N_STATE * N_STATE;
  localparam int C_BASE      = B_BASE + N_STATE * N_CTRL;
  localparam int TABLE_DEPTH = C_BASE + N_OUT * N_STATE;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int ELEM_W      = 2;
  localparam int CNT_W       = 3;
  localparam int TERM_W      = 3;

  localparam int FRAC_SHIFT = 12;
  localparam int PROD_W     = DATA_WIDTH + COEF_WIDTH;
  localparam int ACC_W      = PROD_W + 3;
  localparam int ONE_Q12    = 4096;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_PREDICT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_STATE_USED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUTS_USED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUTS_USED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EMIT_OUTPUTS = 2'd3;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [COEF_WIDTH-1:0] coef_t;

  typedef enum logic {
    KIND_STATE  = 1'b0,
    KIND_OUTPUT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    SRC_X  = 2'd0,
    SRC_U  = 2'd1,
    SRC_XN = 2'd2
  } src_e;

  typedef struct packed {
    logic              load;
    logic              wr;
    logic              mac;
    logic              clr;
    logic [ADDR_W-1:0] addr;
    src_e              src;
    logic [ELEM_W-1:0] elem;
    logic              emit;
    kind_e             kind;
    logic [ELEM_W-1:0] element;
    logic              last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  // The table comes out of reset as identity A with zero B and C.
  function automatic coef_t coef_reset_value(logic [ADDR_W-1:0] idx);
    coef_t val;
    val = '0;
    if ((int'(idx) < B_BASE) && (int'(idx) / N_STATE == int'(idx) % N_STATE)) begin
      val = COEF_WIDTH'(ONE_Q12);
    end
    return val;
  endfunction

endpackage

>>> rtl/ssmp_if.sv
interface ssmp_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     op;
  logic [ssmp_pkg::ADDR_W-1:0]              coef_index;
  logic signed [ssmp_pkg::COEF_WIDTH-1:0]   coef_value;
  logic signed [ssmp_pkg::DATA_WIDTH-1:0]   state_in_0;
  logic signed [ssmp_pkg::DATA_WIDTH-1:0]   state_in_1;
  logic signed [ssmp_pkg::DATA_WIDTH-1:0]   state_in_2;
  logic signed [ssmp_pkg::DATA_WIDTH-1:0]   state_in_3;
  logic signed [ssmp_pkg::DATA_WIDTH-1:0]   ctrl_in_0;
  logic signed [ssmp_pkg::DATA_WIDTH-1:0]   ctrl_in_1;

  modport source (output valid, op, coef_index, coef_value, state_in_0, state_in_1,
                  state_in_2, state_in_3, ctrl_in_0, ctrl_in_1, input ready);
  modport sink   (input valid, op, coef_index, coef_value, state_in_0, state_in_1,
                  state_in_2, state_in_3, ctrl_in_0, ctrl_in_1, output ready);
endinterface

interface ssmp_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   kind;
  logic [ssmp_pkg::ELEM_W-1:0]            element;
  logic signed [ssmp_pkg::DATA_WIDTH-1:0] value;
  logic                                   last;

  modport source (output valid, kind, element, value, last, input ready);
  modport sink   (input valid, kind, element, value, last, output ready);
endinterface

interface ssmp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ssmp_pkg::CFG_IDX_W-1:0]     index;
  logic [ssmp_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/ssmp_ctrl.sv
module ssmp_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_op_i,
  output logic                            in_ready_o,
  input  logic                            cfg_valid_i,
  input  logic [ssmp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ssmp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            cfg_ready_o,
  output ssmp_pkg::dp_cmd_t               cmd_o,
  input  ssmp_pkg::dp_sts_t               sts_i
);
  import ssmp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  kind_e               kind_q, kind_d;
  logic [ELEM_W-1:0]   row_q, row_d;
  logic [TERM_W-1:0]   term_q, term_d;
  logic                drain_q, drain_d;

  logic [CNT_W-1:0]    state_used_q;
  logic [1:0]          inputs_used_q;
  logic [1:0]          outputs_used_q;
  logic                emit_outputs_q;

  logic [CNT_W-1:0]    n_cnt, m_cnt, p_cnt, terms, row_ext;
  logic                accept, row_last, is_last;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_used_q   <= CNT_W'(N_STATE);
      inputs_used_q  <= 2'(N_CTRL);
      outputs_used_q <= 2'(N_OUT);
      emit_outputs_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_STATE_USED:   state_used_q   <= cfg_data_i;
        CFG_INPUTS_USED:  inputs_used_q  <= cfg_data_i[1:0];
        CFG_OUTPUTS_USED: outputs_used_q <= cfg_data_i[1:0];
        CFG_EMIT_OUTPUTS: emit_outputs_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective counts, clamped into the ranges the table layout supports.
  always_comb begin
    n_cnt = state_used_q;
    if (n_cnt == '0) n_cnt = CNT_W'(1);
    if (n_cnt > CNT_W'(N_STATE)) n_cnt = CNT_W'(N_STATE);
    m_cnt = CNT_W'(inputs_used_q);
    if (m_cnt > CNT_W'(N_CTRL)) m_cnt = CNT_W'(N_CTRL);
    p_cnt = CNT_W'(outputs_used_q);
    if (p_cnt > CNT_W'(N_OUT)) p_cnt = CNT_W'(N_OUT);
    if (!emit_outputs_q) p_cnt = '0;
  end

  assign terms    = (kind_q == KIND_STATE) ? n_cnt + m_cnt : n_cnt;
  assign row_ext  = CNT_W'(row_q);
  assign row_last = (kind_q == KIND_STATE) ? (row_ext == n_cnt - CNT_W'(1))
                                           : (row_ext == p_cnt - CNT_W'(1));
  assign is_last  = row_last && ((kind_q == KIND_OUTPUT) || (p_cnt == '0));

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o         = '0;
    cmd_o.src     = SRC_X;
    cmd_o.kind    = kind_q;
    cmd_o.element = row_q;
    cmd_o.last    = is_last;
    cmd_o.load    = accept && (in_op_i == OP_PREDICT);
    cmd_o.wr      = accept && (in_op_i == OP_WRITE);
    cmd_o.mac     = (state_q == ST_RUN);
    cmd_o.clr     = (term_q == '0);
    cmd_o.emit    = (state_q == ST_EMIT) && sts_i.out_free;
    if (kind_q == KIND_OUTPUT) begin
      cmd_o.addr = ADDR_W'(C_BASE) + ADDR_W'(row_q) * ADDR_W'(N_STATE) + ADDR_W'(term_q);
      cmd_o.src  = SRC_XN;
      cmd_o.elem = ELEM_W'(term_q);
    end else if (CNT_W'(term_q) < n_cnt) begin
      cmd_o.addr = ADDR_W'(row_q) * ADDR_W'(N_STATE) + ADDR_W'(term_q);
      cmd_o.src  = SRC_X;
      cmd_o.elem = ELEM_W'(term_q);
    end else begin
      cmd_o.addr = ADDR_W'(B_BASE) + ADDR_W'(row_q) * ADDR_W'(N_CTRL)
                 + ADDR_W'(CNT_W'(term_q) - n_cnt);
      cmd_o.src  = SRC_U;
      cmd_o.elem = ELEM_W'(CNT_W'(term_q) - n_cnt);
    end
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    row_d   = row_q;
    term_d  = term_q;
    drain_d = drain_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_op_i == OP_PREDICT)) begin
          state_d = ST_RUN;
          kind_d  = KIND_STATE;
          row_d   = '0;
          term_d  = '0;
        end
      end
      ST_RUN: begin
        if (CNT_W'(term_q) == terms - CNT_W'(1)) begin
          state_d = ST_DRAIN;
          drain_d = 1'b0;
        end else begin
          term_d = term_q + TERM_W'(1);
        end
      end
      // The drain state lets the last product reach the accumulator.
      ST_DRAIN: begin
        if (drain_q) state_d = ST_EMIT;
        else drain_d = 1'b1;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          term_d = '0;
          if (is_last) begin
            state_d = ST_IDLE;
          end else if (row_last) begin
            state_d = ST_RUN;
            kind_d  = KIND_OUTPUT;
            row_d   = '0;
          end else begin
            state_d = ST_RUN;
            row_d   = row_q + ELEM_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_STATE;
      row_q   <= '0;
      term_q  <= '0;
      drain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      row_q   <= row_d;
      term_q  <= term_d;
      drain_q <= drain_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result issued while the output register is full");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> (state_q == ST_IDLE))
    else $error("controller kept running after the last result");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> ((kind_q == KIND_STATE) ? (row_ext < n_cnt) : (row_ext < p_cnt)))
    else $error("row index beyond the used count");

  a_term_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (CNT_W'(term_q) < terms))
    else $error("term index beyond the row length");
`endif

endmodule

>>> rtl/ssmp_dp.sv
module ssmp_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ssmp_pkg::dp_cmd_t             cmd_i,
  output ssmp_pkg::dp_sts_t             sts_o,
  input  logic [ssmp_pkg::ADDR_W-1:0]   coef_index_i,
  input  ssmp_pkg::coef_t               coef_value_i,
  input  ssmp_pkg::data_t               state_in_i [ssmp_pkg::N_STATE],
  input  ssmp_pkg::data_t               ctrl_in_i [ssmp_pkg::N_CTRL],
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_kind_o,
  output logic [ssmp_pkg::ELEM_W-1:0]   out_element_o,
  output ssmp_pkg::data_t               out_value_o,
  output logic                          out_last_o
);
  import ssmp_pkg::*;

  localparam int RQ_W = ACC_W + 1 - FRAC_SHIFT;
  localparam logic signed [RQ_W-1:0] Q_MAX = RQ_W'(2 ** (DATA_WIDTH - 1) - 1);
  localparam logic signed [RQ_W-1:0] Q_MIN = -Q_MAX - RQ_W'(1);
  localparam logic signed [ACC_W:0]  ROUND_HALF = (ACC_W + 1)'(2 ** (FRAC_SHIFT - 1));

  coef_t                   mem_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  cvalid_q;

  data_t                   x_q [N_STATE];
  data_t                   u_q [N_CTRL];
  data_t                   xn_q [N_STATE];

  coef_t                   rd_data_q;
  logic                    rd_valid_q;
  logic [ADDR_W-1:0]       rd_idx_q;
  data_t                   opnd_q, opnd_d;
  logic                    s1_mac_q, s1_clr_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                    s2_mac_q, s2_clr_q;
  logic signed [ACC_W-1:0] acc_q;

  coef_t                   coef;
  logic signed [ACC_W:0]   rnd_t;
  logic signed [RQ_W-1:0]  rnd_val;
  data_t                   result;

  // Coefficient store; entries never written read as their reset value.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) mem_q[coef_index_i] <= coef_value_i;
    rd_data_q <= mem_q[cmd_i.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvalid_q <= '0;
    end else if (cmd_i.wr) begin
      cvalid_q[coef_index_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= state_in_i;
      u_q <= ctrl_in_i;
    end
    if (cmd_i.emit && (cmd_i.kind == KIND_STATE)) xn_q[cmd_i.element] <= result;
  end

  always_comb begin
    unique case (cmd_i.src)
      SRC_X:   opnd_d = x_q[cmd_i.elem];
      SRC_U:   opnd_d = u_q[cmd_i.elem[$clog2(N_CTRL)-1:0]];
      SRC_XN:  opnd_d = xn_q[cmd_i.elem];
      default: opnd_d = '0;
    endcase
  end

  assign coef = rd_valid_q ? rd_data_q : coef_reset_value(rd_idx_q);

  // Three-stage multiply-accumulate: table read, product, sum.
  always_ff @(posedge clk_i) begin
    rd_valid_q <= cvalid_q[cmd_i.addr];
    rd_idx_q   <= cmd_i.addr;
    opnd_q     <= opnd_d;
    prod_q     <= coef * opnd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_mac_q <= 1'b0;
      s1_clr_q <= 1'b0;
      s2_mac_q <= 1'b0;
      s2_clr_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      s1_mac_q <= cmd_i.mac;
      s1_clr_q <= cmd_i.clr;
      s2_mac_q <= s1_mac_q;
      s2_clr_q <= s1_clr_q;
      if (s2_mac_q) acc_q <= (s2_clr_q ? '0 : acc_q) + ACC_W'(prod_q);
    end
  end

  // Round half up, then saturate to the data width.
  always_comb begin
    rnd_t = (ACC_W + 1)'(acc_q) + ROUND_HALF;
    rnd_val = rnd_t[ACC_W:FRAC_SHIFT];
    if (rnd_val > Q_MAX) result = Q_MAX[DATA_WIDTH-1:0];
    else if (rnd_val < Q_MIN) result = Q_MIN[DATA_WIDTH-1:0];
    else result = rnd_val[DATA_WIDTH-1:0];
  end

  assign sts_o.out_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_o    <= cmd_i.kind;
      out_element_o <= cmd_i.element;
      out_value_o   <= result;
      out_last_o    <= cmd_i.last;
    end
  end

endmodule

>>> rtl/state_space_model_predict_unit.sv
// Discrete state-space predictor: a write beat (op 0) stores one Q4.12
// coefficient into the 32-entry A/B/C table and returns nothing; a
// predict beat (op 1) returns x_next = A*x + B*u, one beat per used state
// element, then y = C*x_next, one beat per used output, with last set on the
// final beat. All terms run through one shared 16x16 multiplier behind a
// three-stage read/multiply/accumulate pipeline, one term per cycle, and each
// row waits for that pipeline to drain before its result is rounded out. No
// new beat is taken until the last result of a prediction has been handed to
// the output register. Configuration writes are taken every cycle and belong
// in idle time only.
module state_space_model_predict_unit (
  input  logic clk_i,
  input  logic rst_ni,
  ssmp_in_if.sink    in_i,
  ssmp_out_if.source out_o,
  ssmp_cfg_if.sink   cfg_i
);
  import ssmp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  data_t   state_vec [N_STATE];
  data_t   ctrl_vec [N_CTRL];

  assign state_vec[0] = in_i.state_in_0;
  assign state_vec[1] = in_i.state_in_1;
  assign state_vec[2] = in_i.state_in_2;
  assign state_vec[3] = in_i.state_in_3;
  assign ctrl_vec[0]  = in_i.ctrl_in_0;
  assign ctrl_vec[1]  = in_i.ctrl_in_1;

  ssmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.op),
    .in_ready_o  (in_i.ready),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cfg_ready_o (cfg_i.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ssmp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .coef_index_i  (in_i.coef_index),
    .coef_value_i  (in_i.coef_value),
    .state_in_i    (state_vec),
    .ctrl_in_i     (ctrl_vec),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_kind_o    (out_o.kind),
    .out_element_o (out_o.element),
    .out_value_o   (out_o.value),
    .out_last_o    (out_o.last)
  );

endmodule

>>> verif/ssmp_predict_check.sv
`timescale 1ns / 1ps

// Watches all three channels of the predictor, keeps its own copy of the
// coefficient table and the use counts, and checks every result beat.
module ssmp_predict_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssmp_in_if          in_i,
  ssmp_out_if         out_i,
  ssmp_cfg_if         cfg_i,
  output int unsigned mismatch_count_o,
  output int unsigned beats_pending_o
);
  import ssmp_pkg::*;

  typedef struct {
    kind_e             kind;
    logic [ELEM_W-1:0] element;
    data_t             value;
    logic              last;
  } result_beat_t;

  coef_t                 coef_tbl [TABLE_DEPTH];
  logic [CFG_DATA_W-1:0] state_used_q;
  logic [1:0]            inputs_used_q;
  logic [1:0]            outputs_used_q;
  logic                  emit_outputs_q;
  result_beat_t          pending_beats [$];
  int unsigned           mismatches = 0;

  assign mismatch_count_o = mismatches;

  // Round half up from Q.12 to Q8.8, then clip to the data width.
  function automatic data_t round_sat_q88(longint acc);
    longint q;
    longint hi;
    longint lo;
    hi = (longint'(1) << (DATA_WIDTH - 1)) - 1;
    lo = -hi - 1;
    q  = (acc + (longint'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    if (q > hi) begin
      q = hi;
    end else if (q < lo) begin
      q = lo;
    end
    return data_t'(q);
  endfunction

  task automatic queue_prediction();
    data_t        x [N_STATE];
    data_t        u [N_CTRL];
    data_t        xn [N_STATE];
    int           n;
    int           m;
    int           p;
    int           total;
    longint       acc;
    result_beat_t beat;
    n = int'(state_used_q);
    if (n < 1) n = 1;
    if (n > N_STATE) n = N_STATE;
    m = int'(inputs_used_q);
    if (m > N_CTRL) m = N_CTRL;
    p = int'(outputs_used_q);
    if (p > N_OUT) p = N_OUT;
    if (!emit_outputs_q) p = 0;
    total = n + p;
    x[0] = in_i.state_in_0;
    x[1] = in_i.state_in_1;
    x[2] = in_i.state_in_2;
    x[3] = in_i.state_in_3;
    u[0] = in_i.ctrl_in_0;
    u[1] = in_i.ctrl_in_1;
    for (int i = 0; i < n; i++) begin
      acc = 0;
      for (int j = 0; j < n; j++) begin
        acc += longint'(coef_tbl[i * N_STATE + j]) * longint'(x[j]);
      end
      for (int j = 0; j < m; j++) begin
        acc += longint'(coef_tbl[B_BASE + i * N_CTRL + j]) * longint'(u[j]);
      end
      xn[i]        = round_sat_q88(acc);
      beat.kind    = KIND_STATE;
      beat.element = ELEM_W'(i);
      beat.value   = xn[i];
      beat.last    = (i == total - 1);
      pending_beats.push_back(beat);
    end
    // The outputs are built from the already clipped next state.
    for (int i = 0; i < p; i++) begin
      acc = 0;
      for (int j = 0; j < n; j++) begin
        acc += longint'(coef_tbl[C_BASE + i * N_STATE + j]) * longint'(xn[j]);
      end
      beat.kind    = KIND_OUTPUT;
      beat.element = ELEM_W'(i);
      beat.value   = round_sat_q88(acc);
      beat.last    = (n + i == total - 1);
      pending_beats.push_back(beat);
    end
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_beat_t want;
    if (!rst_ni) begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        coef_tbl[k] = '0;
      end
      for (int k = 0; k < N_STATE; k++) begin
        coef_tbl[k * N_STATE + k] = coef_t'(ONE_Q12);
      end
      state_used_q   = 3'd4;
      inputs_used_q  = 2'd2;
      outputs_used_q = 2'd2;
      emit_outputs_q = 1'b1;
      pending_beats.delete();
      beats_pending_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_STATE_USED:   state_used_q   = cfg_i.data;
          CFG_INPUTS_USED:  inputs_used_q  = cfg_i.data[1:0];
          CFG_OUTPUTS_USED: outputs_used_q = cfg_i.data[1:0];
          CFG_EMIT_OUTPUTS: emit_outputs_q = cfg_i.data[0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        if (in_i.op == OP_WRITE) begin
          if (int'(in_i.coef_index) < TABLE_DEPTH) begin
            coef_tbl[in_i.coef_index] = in_i.coef_value;
          end
        end else begin
          queue_prediction();
        end
      end
      if (out_i.valid && out_i.ready) begin
        if (pending_beats.size() == 0) begin
          $error("unexpected result beat: kind %0d element %0d value %0d",
                 out_i.kind, out_i.element, out_i.value);
          mismatches++;
        end else begin
          want = pending_beats.pop_front();
          check_field("kind", longint'(want.kind), longint'(out_i.kind));
          check_field("element", longint'(want.element), longint'(out_i.element));
          check_field("value", longint'(want.value), longint'(out_i.value));
          check_field("last", longint'(want.last), longint'(out_i.last));
        end
      end
      beats_pending_o <= pending_beats.size();
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ssmp_pkg::*;

  localparam int DRAIN_CYCLES    = 16;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 75;

  typedef struct packed {
    logic                      op;
    logic [ADDR_W-1:0]         coef_index;
    coef_t                     coef_value;
    data_t [N_STATE-1:0]       state;
    data_t [N_CTRL-1:0]        ctrl;
  } model_step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned mismatch_count;
  int unsigned beats_pending;
  int unsigned gap_odds;
  int unsigned stall_odds;

  ssmp_in_if  in_bus ();
  ssmp_out_if out_bus ();
  ssmp_cfg_if cfg_bus ();

  always #5 clk_i = ~clk_i;

  state_space_model_predict_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  ssmp_predict_check i_predict_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (in_bus),
    .out_i            (out_bus),
    .cfg_i            (cfg_bus),
    .mismatch_count_o (mismatch_count),
    .beats_pending_o  (beats_pending)
  );

  function automatic data_t pick_q88();
    case ($urandom_range(0, 7))
      0: return data_t'(16'h7FFF);
      1: return data_t'(16'h8000);
      2, 3: return data_t'($urandom);
      default: return data_t'(int'($urandom_range(0, 4095)) - 2048);
    endcase
  endfunction

  function automatic coef_t pick_coef();
    case ($urandom_range(0, 7))
      0: return coef_t'(16'h7FFF);
      1: return coef_t'(16'h8000);
      2: return coef_t'($urandom);
      default: return coef_t'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  function automatic model_step_t random_step(logic op);
    model_step_t s;
    s.op         = op;
    s.coef_index = ADDR_W'($urandom_range(0, TABLE_DEPTH - 1));
    s.coef_value = pick_coef();
    for (int i = 0; i < N_STATE; i++) s.state[i] = pick_q88();
    for (int i = 0; i < N_CTRL; i++) s.ctrl[i] = pick_q88();
    return s;
  endfunction

  // Returns at the edge where the beat is taken, with valid still high.
  task automatic send_beat(model_step_t s);
    in_bus.valid      <= 1'b1;
    in_bus.op         <= s.op;
    in_bus.coef_index <= s.coef_index;
    in_bus.coef_value <= s.coef_value;
    in_bus.state_in_0 <= s.state[0];
    in_bus.state_in_1 <= s.state[1];
    in_bus.state_in_2 <= s.state[2];
    in_bus.state_in_3 <= s.state[3];
    in_bus.ctrl_in_0  <= s.ctrl[0];
    in_bus.ctrl_in_1  <= s.ctrl[1];
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  task automatic sender_gap();
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic write_coef(int idx, coef_t val);
    model_step_t s;
    s            = random_step(OP_WRITE);
    s.coef_index = ADDR_W'(idx);
    s.coef_value = val;
    sender_gap();
    send_beat(s);
  endtask

  task automatic predict_vec(data_t x0, data_t x1, data_t x2, data_t x3,
                             data_t u0, data_t u1);
    model_step_t s;
    s          = random_step(OP_PREDICT);
    s.state[0] = x0;
    s.state[1] = x1;
    s.state[2] = x2;
    s.state[3] = x3;
    s.ctrl[0]  = u0;
    s.ctrl[1]  = u1;
    sender_gap();
    send_beat(s);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (beats_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
  endtask

  // Unused upper data bits are filled at random; the block ignores them.
  task automatic set_config(logic [2:0] n_state, logic [1:0] n_ctrl, logic [1:0] n_out,
                            logic emit);
    logic [CFG_DATA_W-1:0] pad;
    pad = CFG_DATA_W'($urandom);
    wait_idle();
    write_reg(CFG_STATE_USED, n_state);
    write_reg(CFG_INPUTS_USED, {pad[2], n_ctrl});
    write_reg(CFG_OUTPUTS_USED, {pad[1], n_out});
    write_reg(CFG_EMIT_OUTPUTS, {pad[2:1], emit});
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    out_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [2:0] plan_state [RANDOM_PHASES];
    logic [1:0] plan_ctrl  [RANDOM_PHASES];
    logic [1:0] plan_out   [RANDOM_PHASES];
    logic       plan_emit  [RANDOM_PHASES];
    logic       op;

    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.op          = OP_WRITE;
    in_bus.coef_index  = '0;
    in_bus.coef_value  = '0;
    in_bus.state_in_0  = '0;
    in_bus.state_in_1  = '0;
    in_bus.state_in_2  = '0;
    in_bus.state_in_3  = '0;
    in_bus.ctrl_in_0   = '0;
    in_bus.ctrl_in_1   = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = CFG_STATE_USED;
    cfg_bus.data       = '0;
    gap_odds           = 4;
    stall_odds         = 4;

    plan_state = '{3'd1, 3'd7, 3'd0, 3'd4, 3'd3, 3'd2};
    plan_ctrl  = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd2, 2'd1};
    plan_out   = '{2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1};
    plan_emit  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset A is identity, so the state passes straight through.
    predict_vec(16'sh7FFF, -16'sd32768, 16'sd0, 16'sd1, 16'sd5, -16'sd5);
    // A half coefficient exposes rounding on exact halves of either sign.
    write_coef(0, 16'sd2048);
    predict_vec(16'sd1, -16'sd1, 16'sd3, -16'sd3, 16'sd0, 16'sd0);
    predict_vec(-16'sd1, 16'sd3, -16'sd3, 16'sd1, 16'sd0, 16'sd0);
    predict_vec(16'sd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    predict_vec(-16'sd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    // Extreme coefficients push the accumulator into saturation.
    write_coef(1, 16'sh7FFF);
    write_coef(16, -16'sd32768);
    write_coef(17, 16'sh7FFF);
    write_coef(24, 16'sd4096);
    write_coef(27, 16'sh7FFF);
    write_coef(31, -16'sd32768);
    predict_vec(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sd32768, 16'sh7FFF);
    predict_vec(-16'sd32768, -16'sd32768, 16'sh7FFF, -16'sd32768, 16'sh7FFF, -16'sd32768);

    // A zero state count acts as one, with no inputs and no outputs.
    set_config(3'd0, 2'd0, 2'd0, 1'b1);
    predict_vec(16'sd300, -16'sd700, 16'sd1, 16'sd2, 16'sd3, 16'sd4);
    // Counts above the sizes saturate.
    set_config(3'd7, 2'd3, 2'd3, 1'b1);
    predict_vec(16'sd1000, -16'sd2000, 16'sd300, -16'sd4, 16'sd50, -16'sd60);
    // Outputs switched off: the last state beat carries last.
    set_config(3'd2, 2'd1, 2'd2, 1'b0);
    predict_vec(-16'sd1000, 16'sd2000, 16'sd0, 16'sd0, 16'sd700, 16'sd0);
    set_config(3'd4, 2'd2, 2'd0, 1'b1);
    predict_vec(16'sd256, 16'sd512, -16'sd256, -16'sd512, 16'sd128, -16'sd128);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == RANDOM_PHASES - 1) begin
        set_config(3'($urandom_range(1, 4)), 2'($urandom_range(0, 2)),
                   2'($urandom_range(0, 2)), 1'b1);
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        set_config(plan_state[ph], plan_ctrl[ph], plan_out[ph], plan_emit[ph]);
        case ($urandom_range(0, 2))
          0: gap_odds = 0;
          1: gap_odds = 3;
          default: gap_odds = 8;
        endcase
        case ($urandom_range(0, 2))
          0: stall_odds = 0;
          1: stall_odds = 3;
          default: stall_odds = 8;
        endcase
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        op = ($urandom_range(0, 2) == 0) ? OP_WRITE : OP_PREDICT;
        sender_gap();
        send_beat(random_step(op));
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
